### hdl/nwap_pkg.sv
`default_nettype none

package nwap_pkg;

  // Field widths of the channels and the configuration register.
  localparam int KIND_W     = 3;
  localparam int NODE_W     = 6;
  localparam int VALUE_W    = 16;
  localparam int DIST_OUT_W = 24;
  localparam int CFG_W      = 7;

  // Stored distances never exceed the no-path value, which fits in 20 bits.
  localparam int DW = 20;

  localparam logic [DW-1:0]    NO_PATH        = 20'd999999;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 3'd0,
    KIND_COST  = 3'd1,
    KIND_EDGE  = 3'd2,
    KIND_RUN   = 3'd3,
    KIND_QUERY = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COST,
    ST_EDGE_RD,
    ST_EDGE_AB,
    ST_EDGE_BA,
    ST_FW_FETCH,
    ST_FW_SWEEP,
    ST_FW_DRAIN,
    ST_QUERY_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic item_load;
    logic clr_step;
    logic cost_wr;
    logic cost_rd;
    logic edge_wr_ab;
    logic edge_wr_ba;
    logic fw_fetch;
    logic fw_sweep;
    logic query_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/nwap_if.sv
`default_nettype none

interface nwap_item_if import nwap_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;
  logic [VALUE_W-1:0] value;

  modport source (output valid, kind, node_a, node_b, value, input ready);
  modport sink   (input valid, kind, node_a, node_b, value, output ready);
endinterface

interface nwap_result_if import nwap_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  done_res;
  logic [DIST_OUT_W-1:0] distance;

  modport source (output valid, done_res, distance, input ready);
  modport sink   (input valid, done_res, distance, output ready);
endinterface

`default_nettype wire

### hdl/nwap_dpath.sv
`default_nettype none

module nwap_dpath import nwap_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic [KIND_W-1:0]     item_kind,
  input  wire logic [NODE_W-1:0]     item_node_a,
  input  wire logic [NODE_W-1:0]     item_node_b,
  input  wire logic [VALUE_W-1:0]    item_value,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic                       out_done_res,
  output logic [DIST_OUT_W-1:0]      out_distance
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;

  logic [CFG_W-1:0]   node_count;
  logic [CW-1:0]      n_eff;
  logic [CW-1:0]      n_last;

  kind_t              kind_q;
  logic [NODE_W-1:0]  a_q;
  logic [NODE_W-1:0]  b_q;
  logic [VALUE_W-1:0] value_q;
  logic [NW-1:0]      a_idx;
  logic [NW-1:0]      b_idx;
  logic               pair_ok;
  logic               cost_ok;

  logic [NW-1:0]      k;
  logic [NW-1:0]      i;
  logic [NW-1:0]      j;
  logic [AW-1:0]      clr_addr;

  logic [DW-1:0]      dist_mem [0:DEPTH-1];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic               rd_a_en;
  logic [AW-1:0]      rd_a_addr;
  logic [DW-1:0]      rd_a;
  logic [AW-1:0]      rd_b_addr;
  logic [DW-1:0]      rd_b;

  logic [VALUE_W-1:0] cost_mem [0:MAX_NODES-1];
  logic [VALUE_W-1:0] cost_a;
  logic [VALUE_W-1:0] cost_b;

  logic               fetch_d;
  logic               relax_d;
  logic [AW-1:0]      relax_addr;
  logic [DW-1:0]      dik;
  logic [DW:0]        via;
  logic               relax_wr;
  logic [DW-1:0]      sum_ab;
  logic [DW-1:0]      sum_ba;

  // Effective node count: zero acts as one, anything above the capacity is clamped.
  always_comb begin
    if (node_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count);
    end
  end

  assign n_last  = n_eff - CW'(1);
  assign a_idx   = NW'(a_q);
  assign b_idx   = NW'(b_q);
  assign pair_ok = (32'(a_q) < 32'(n_eff)) && (32'(b_q) < 32'(n_eff));
  assign cost_ok = 32'(a_q) < MAX_NODES;

  assign sts.clr_last = &clr_addr;
  assign sts.j_last   = CW'(j) == n_last;
  assign sts.i_last   = CW'(i) == n_last;
  assign sts.k_last   = CW'(k) == n_last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      kind_q  <= kind_t'(item_kind);
      a_q     <= item_node_a;
      b_q     <= item_node_b;
      value_q <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      i        <= '0;
      j        <= '0;
      clr_addr <= '0;
    end else if (cmd.item_load) begin
      k        <= '0;
      i        <= '0;
      j        <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.fw_sweep) begin
        if (sts.j_last) begin
          j <= '0;
          if (sts.i_last) begin
            i <= '0;
            k <= k + NW'(1);
          end else begin
            i <= i + NW'(1);
          end
        end else begin
          j <= j + NW'(1);
        end
      end
    end
  end

  // Relaxation: dist[i][k] is latched once per row, row k is read alongside row i.
  assign via      = {1'b0, dik} + {1'b0, rd_b};
  assign relax_wr = relax_d && (via < {1'b0, rd_a});

  assign sum_ab = DW'({1'b0, value_q} + {1'b0, cost_b});
  assign sum_ba = DW'({1'b0, value_q} + {1'b0, cost_a});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (relax_wr) begin
      wr_en   = 1'b1;
      wr_addr = relax_addr;
      wr_data = via[DW-1:0];
    end else if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = (clr_addr[AW-1:NW] == clr_addr[NW-1:0]) ? '0 : NO_PATH;
    end else if (cmd.edge_wr_ab && pair_ok) begin
      wr_en   = 1'b1;
      wr_addr = {a_idx, b_idx};
      wr_data = sum_ab;
    end else if (cmd.edge_wr_ba && pair_ok) begin
      wr_en   = 1'b1;
      wr_addr = {b_idx, a_idx};
      wr_data = sum_ba;
    end
  end

  always_comb begin
    rd_a_en   = cmd.fw_fetch || cmd.fw_sweep || cmd.query_rd;
    rd_a_addr = {a_idx, b_idx};
    if (cmd.fw_fetch) begin
      rd_a_addr = {i, k};
    end else if (cmd.fw_sweep) begin
      rd_a_addr = {i, j};
    end
    rd_b_addr = {k, j};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a <= dist_mem[rd_a_addr];
    end
    if (cmd.fw_sweep) begin
      rd_b <= dist_mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cost_wr && cost_ok) begin
      cost_mem[a_idx] <= value_q;
    end
    if (cmd.cost_rd) begin
      cost_a <= cost_mem[a_idx];
      cost_b <= cost_mem[b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_d <= 1'b0;
      relax_d <= 1'b0;
    end else begin
      fetch_d <= cmd.fw_fetch;
      relax_d <= cmd.fw_sweep;
    end
  end

  always_ff @(posedge clk) begin
    relax_addr <= {i, j};
    if (fetch_d) begin
      dik <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_done_res <= kind_q == KIND_RUN;
      if (kind_q == KIND_RUN) begin
        out_distance <= '0;
      end else if (pair_ok) begin
        out_distance <= DIST_OUT_W'(rd_a);
      end else begin
        out_distance <= DIST_OUT_W'(NO_PATH);
      end
    end
  end

endmodule

`default_nettype wire

### hdl/nwap_ctrl.sv
`default_nettype none

module nwap_ctrl import nwap_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [KIND_W-1:0] in_kind,
  output logic                   in_ready,
  input  wire dp_sts_t           sts,
  output dp_cmd_t                cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_t'(in_kind))
            KIND_CLEAR: state_next = ST_CLEAR;
            KIND_COST:  state_next = ST_COST;
            KIND_EDGE:  state_next = ST_EDGE_RD;
            KIND_RUN:   state_next = ST_FW_FETCH;
            KIND_QUERY: state_next = ST_QUERY_RD;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_COST:     state_next = ST_IDLE;
      ST_EDGE_RD:  state_next = ST_EDGE_AB;
      ST_EDGE_AB:  state_next = ST_EDGE_BA;
      ST_EDGE_BA:  state_next = ST_IDLE;
      ST_FW_FETCH: state_next = ST_FW_SWEEP;
      ST_FW_SWEEP: begin
        if (sts.j_last) begin
          state_next = (sts.i_last && sts.k_last) ? ST_FW_DRAIN : ST_FW_FETCH;
        end
      end
      ST_FW_DRAIN: state_next = ST_RESP;
      ST_QUERY_RD: state_next = ST_RESP;
      ST_RESP: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.item_load = in_valid;
      end
      ST_CLEAR:    cmd.clr_step   = 1'b1;
      ST_COST:     cmd.cost_wr    = 1'b1;
      ST_EDGE_RD:  cmd.cost_rd    = 1'b1;
      ST_EDGE_AB:  cmd.edge_wr_ab = 1'b1;
      ST_EDGE_BA:  cmd.edge_wr_ba = 1'b1;
      ST_FW_FETCH: cmd.fw_fetch   = 1'b1;
      ST_FW_SWEEP: cmd.fw_sweep   = 1'b1;
      ST_QUERY_RD: cmd.query_rd   = 1'b1;
      ST_RESP:     cmd.out_load   = sts.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/node_weighted_all_pairs_shortest_path_unit.sv
// Items are taken one at a time; the run time is set by the single relaxation per cycle
// through the two-read, one-write distance memory.
// Reset clears the sequencer and the result valid flag and sets node_count to 64; the distance
// matrix and node costs hold no defined value until a clear item or a cost item writes them.
`default_nettype none

module node_weighted_all_pairs_shortest_path_unit import nwap_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  nwap_item_if.sink             item,
  nwap_result_if.source         result
);

  // The controller sequences each item; the datapath holds the matrix, the node costs,
  // the loop counters and the result register. They talk only through cmd and sts.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Each accepted beat is latched in the datapath, then the controller walks the states
  // for its kind. A run sweeps k outer, i, then j: a fetch state reads dist[i][k], then one
  // relaxation issues per cycle for every j, its write landing in the following cycle. Row k and
  // column k cannot shrink during pass k, since the weights are never negative, so the
  // in-place updates never race the reads.
  nwap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_kind  (item.kind),
    .in_ready (item.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The result register lets a finished result wait for the sink while the controller
  // returns to idle and takes the next beat.
  nwap_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_kind    (item.kind),
    .item_node_a  (item.node_a),
    .item_node_b  (item.node_b),
    .item_value   (item.value),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_done_res (result.done_res),
    .out_distance (result.distance)
  );

endmodule

`default_nettype wire

### sim/tb_node_weighted_all_pairs_shortest_path_unit.sv
`timescale 1ns / 100ps

module tb_node_weighted_all_pairs_shortest_path_unit;
  import nwap_pkg::*;

  // The block is built at its default size; the graph mirror below has the same size.
  localparam int unsigned NODES = 64;

  // Kinds 5 to 7 are spare codes that the block must swallow without a result.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI  = 3'd7;

  // A clear walks the whole matrix. It gives no result beat,
  // so after the last expected result we still have to sit out a clear before touching
  // the register or ending the run.
  localparam int unsigned DRAIN_CYCLES = 4300;

  // The one full-size closure and every clear dominate the run time; the rest
  // of the run is small next to those. The limit is several times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [VALUE_W-1:0] value;
  } graph_item_t;

  typedef struct packed {
    logic                  done_res;
    logic [DIST_OUT_W-1:0] distance;
  } answer_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  nwap_item_if   item_ch ();
  nwap_result_if result_ch ();

  node_weighted_all_pairs_shortest_path_unit #(
    .MAX_NODES(NODES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (item_ch),
    .result   (result_ch)
  );

  always #5 clk = ~clk;

  // Items waiting to be offered, and the results we are owed, oldest first.
  graph_item_t item_backlog[$];
  answer_t     awaited_answers[$];

  // Our own mirror of the block: distance matrix, node costs and the node count register.
  int unsigned        dist_now [NODES][NODES];
  logic [VALUE_W-1:0] cost_now [NODES];
  logic [CFG_W-1:0]   nodes_cfg = NODE_COUNT_RST;

  // Which node costs the stimulus has already written. An edge must never pick up the
  // cost of a node that was never written, since that value is undefined in the block.
  bit cost_known [NODES];

  // Per-phase switches that take all idling away from one side.
  bit src_eager  = 1'b0;
  bit sink_eager = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  logic        hold_kick = 1'b0;
  graph_item_t on_wire;

  // ---------------------------------------------------------------------------------------
  // Mirror of the block
  // ---------------------------------------------------------------------------------------

  // A register value of 0 behaves as one node, and anything above the build size as the
  // build size.
  function automatic int unsigned active_count();
    if (nodes_cfg == 0) return 1;
    if (nodes_cfg > NODES) return NODES;
    return 32'(nodes_cfg);
  endfunction

  // Applies one accepted item to the mirror and queues the result beat it owes, if any.
  function automatic void advance_graph(graph_item_t it);
    int unsigned n;
    int unsigned via;
    answer_t     ans;
    n = active_count();
    ans = '0;
    case (it.kind)
      KIND_CLEAR: begin
        // The whole matrix is cleared, whatever the node count says.
        for (int r = 0; r < NODES; r++)
          for (int c = 0; c < NODES; c++)
            dist_now[r][c] = (r == c) ? 0 : 32'(NO_PATH);
      end
      KIND_COST: begin
        cost_now[it.node_a] = it.value;
      end
      KIND_EDGE: begin
        // Both directions take the cost of the node they enter, as held right now. An end
        // outside the active nodes drops the whole edge.
        if (it.node_a < n && it.node_b < n) begin
          dist_now[it.node_a][it.node_b] = 32'(it.value) + 32'(cost_now[it.node_b]);
          dist_now[it.node_b][it.node_a] = 32'(it.value) + 32'(cost_now[it.node_a]);
        end
      end
      KIND_RUN: begin
        // Relaxation in place, intermediate node outermost. No entry ever rises above the
        // no-path value, so a path of that length or more is simply never found.
        for (int k = 0; k < n; k++)
          for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
              via = dist_now[i][k] + dist_now[k][j];
              if (via < dist_now[i][j]) dist_now[i][j] = via;
            end
        ans.done_res = 1'b1;
        awaited_answers.push_back(ans);
      end
      KIND_QUERY: begin
        // A query outside the active nodes reads as no path at all.
        if (it.node_a < n && it.node_b < n)
          ans.distance = dist_now[it.node_a][it.node_b][DIST_OUT_W-1:0];
        else
          ans.distance = DIST_OUT_W'(NO_PATH);
        awaited_answers.push_back(ans);
      end
      default: begin
        // Spare kinds leave everything alone.
      end
    endcase
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_answer(logic done_bit, logic [DIST_OUT_W-1:0] dist_bits);
    answer_t want;
    if (awaited_answers.size() == 0) begin
      note_mismatch($sformatf("result beat with nothing owed: done_res=%0b distance=%0d",
                              done_bit, dist_bits));
      return;
    end
    want = awaited_answers.pop_front();
    if (done_bit !== want.done_res)
      note_mismatch($sformatf("done_res %0b, expected %0b", done_bit, want.done_res));
    if (dist_bits !== want.distance)
      note_mismatch($sformatf("distance %0d, expected %0d", dist_bits, want.distance));
  endtask

  // Idle cycles that one side waits before its next beat. About a third of the draws
  // are zero so that back-to-back beats stay common even when idling is on.
  function automatic int unsigned draw_wait(bit eager);
    if (eager) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item driver: offers the backlog one beat at a time and feeds every accepted beat to the
  // mirror at the very edge that accepts it.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) advance_graph(on_wire);
      if (!item_ch.valid || item_ch.ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          item_ch.valid <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          on_wire = item_backlog.pop_front();
          item_ch.kind   <= on_wire.kind;
          item_ch.node_a <= on_wire.node_a;
          item_ch.node_b <= on_wire.node_b;
          item_ch.value  <= on_wire.value;
          item_ch.valid  <= 1'b1;
          src_gap <= draw_wait(src_eager);
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor: checks every accepted result beat and decides when ready is offered.
  // A long hold-off, when one is running, overrides the usual per-beat stalls.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : answer_monitor
    int unsigned w;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        check_answer(result_ch.done_res, result_ch.distance);
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
      end else if (result_ch.valid && result_ch.ready) begin
        w = draw_wait(sink_eager);
        sink_gap <= w;
        result_ch.ready <= (w == 0);
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        result_ch.ready <= (sink_gap == 1);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // The long hold-off counts its own cycles, started by a one-cycle kick.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("node_weighted_all_pairs_shortest_path_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  task automatic queue_item(logic [KIND_W-1:0] kind, int unsigned a, int unsigned b,
                            int unsigned v);
    graph_item_t it;
    it.kind   = kind;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.value  = VALUE_W'(v);
    item_backlog.push_back(it);
  endtask

  task automatic queue_cost(int unsigned node, int unsigned v);
    queue_item(KIND_COST, node, $urandom_range(0, NODES - 1), v);
    cost_known[node % NODES] = 1'b1;
  endtask

  // Writes any missing end cost first, so that no edge ever reads an unwritten cost.
  task automatic queue_edge(int unsigned a, int unsigned b, int unsigned w);
    if (!cost_known[a]) queue_cost(a, $urandom_range(0, 30));
    if (!cost_known[b]) queue_cost(b, $urandom_range(0, 30));
    queue_item(KIND_EDGE, a, b, w);
  endtask

  task automatic queue_query(int unsigned a, int unsigned b);
    queue_item(KIND_QUERY, a, b, $urandom_range(0, 65535));
  endtask

  // Mostly a node in use; now and then any node, which may lie outside the active range.
  function automatic int unsigned pick_node(int unsigned n);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, NODES - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // Light weights keep many relaxations alive; full-range ones exercise the wide sums.
  function automatic int unsigned pick_weight();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 40);
  endfunction

  // One graph: clear, some costs, edges with a little noise mixed in, a few queries before
  // the closure, the closure itself (or not, for a broken sequence) and queries after it.
  task automatic graph_session(int unsigned edges, int unsigned queries, bit with_run);
    int unsigned n;
    n = active_count();
    queue_item(KIND_CLEAR, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
               $urandom_range(0, 65535));
    repeat ((n < 6) ? n : 6) queue_cost(pick_node(n), pick_weight());
    repeat (edges) begin
      if ($urandom_range(0, 9) == 0)
        queue_item(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                   $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                   $urandom_range(0, 65535));
      else if ($urandom_range(0, 9) == 0)
        queue_cost(pick_node(n), pick_weight());
      queue_edge(pick_node(n), pick_node(n), pick_weight());
    end
    repeat (queries / 3) queue_query(pick_node(n), pick_node(n));
    if (with_run)
      queue_item(KIND_RUN, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                 $urandom_range(0, 65535));
    repeat (queries) queue_query(pick_node(n), pick_node(n));
  endtask

  // Waits until every queued beat has gone in and every owed result has come back, then
  // lets a full clear's worth of cycles pass in case the last item gave no result.
  task automatic wait_quiet();
    do @(negedge clk);
    while (item_backlog.size() != 0 || item_ch.valid || awaited_answers.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Only ever called with the block idle, so the mirror can take the new count at once.
  task automatic write_node_count(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    nodes_cfg = v;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    item_ch.valid = 1'b0;
    item_ch.kind = '0;
    item_ch.node_a = '0;
    item_ch.node_b = '0;
    item_ch.value = '0;
    result_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset count of 64 nodes. The first item is a clear, so the
    // matrix is defined before anything reads it. Costs and weights sit at the field
    // extremes and at alternating bit patterns; a self edge overwrites a diagonal entry.
    queue_item(KIND_CLEAR, 0, 0, 0);
    queue_cost(0, 0);
    queue_cost(63, 65535);
    queue_edge(0, 63, 65535);
    queue_query(0, 63);
    queue_query(63, 0);
    queue_cost(42, 16'h5555);
    queue_cost(21, 16'hAAAA);
    queue_edge(21, 42, 16'hAAAA);
    queue_edge(42, 42, 7);
    queue_query(42, 42);
    queue_query(21, 42);
    queue_item(KIND_SPARE_LO, 63, 63, 65535);
    queue_item(KIND_SPARE_MID, 0, 63, 0);
    queue_item(KIND_SPARE_HI, 63, 0, 65535);
    wait_quiet();

    // Five nodes: a small chain, an edge to a node beyond the count (dropped), the
    // closure, and a query that falls outside the active nodes.
    write_node_count(7'd5);
    queue_cost(1, 2);
    queue_cost(2, 9);
    queue_edge(0, 1, 3);
    queue_edge(1, 2, 4);
    queue_edge(0, 7, 1);
    queue_item(KIND_RUN, 0, 0, 0);
    queue_query(0, 2);
    queue_query(2, 0);
    queue_query(6, 2);
    graph_session(3, 3, 1'b1);
    wait_quiet();

    // Back-pressure: the receiver holds off for a long stretch while the sender keeps
    // offering queries and a run without a gap, so the result register fills and the input stalls.
    src_eager = 1'b1;
    @(posedge clk);
    hold_kick <= 1'b1;
    @(negedge clk);
    repeat (6) queue_query(pick_node(5), pick_node(5));
    queue_item(KIND_RUN, 0, 0, 0);
    repeat (2) queue_query(pick_node(5), pick_node(5));
    @(posedge clk);
    hold_kick <= 1'b0;
    wait_quiet();
    src_eager = 1'b0;

    // A register value of zero: the block works on a single node.
    write_node_count(7'd0);
    graph_session(2, 3, 1'b1);
    wait_quiet();

    // The largest register value, which acts as the full 64 nodes; this is the one full
    // closure of the run. No idling on either side here.
    src_eager = 1'b1;
    sink_eager = 1'b1;
    write_node_count(7'd127);
    graph_session(3, 3, 1'b1);
    wait_quiet();
    src_eager = 1'b0;
    sink_eager = 1'b0;

    // Full size again, written explicitly this time: loading and queries without a
    // closure, which leaves the graph half built.
    write_node_count(7'd64);
    graph_session(2, 2, 1'b0);
    wait_quiet();

    // A small random size with a complete sequence.
    write_node_count(CFG_W'($urandom_range(2, 12)));
    graph_session(4, 3, 1'b1);
    wait_quiet();

    if (mismatches == 0) begin
      $display("node_weighted_all_pairs_shortest_path_unit regression: pass");
    end else begin
      $display("node_weighted_all_pairs_shortest_path_unit regression: fail");
    end
    $finish;
  end

endmodule
